// ===== src/bfir_pkg.sv =====
// Package: shared constants, register offsets and item types for the board IRQ register file.
`default_nettype none

package bfir_pkg;

  // Number of external interrupt lines that are wired up.
  localparam int unsigned LINE_COUNT = 16;

  // Function codes of an input beat.
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_LINE  = 2'd2;

  // Register byte offsets in the window.
  localparam logic [19:0] OFS_LED_DATA_ONE     = 20'h00010;
  localparam logic [19:0] OFS_LED_DATA_TWO     = 20'h00014;
  localparam logic [19:0] OFS_LED_CONTROL      = 20'h00040;
  localparam logic [19:0] OFS_SWITCH_WORD      = 20'h00060;
  localparam logic [19:0] OFS_MISC_WRITE_ONE   = 20'h00080;
  localparam logic [19:0] OFS_MISC_WRITE_TWO   = 20'h00084;
  localparam logic [19:0] OFS_MISC_WRITE_THREE = 20'h00088;
  localparam logic [19:0] OFS_MISC_READ_WORD   = 20'h00090;
  localparam logic [19:0] OFS_IRQ_ENABLE_MASK  = 20'h000c0;
  localparam logic [19:0] OFS_IRQ_PENDING      = 20'h000d0;
  localparam logic [19:0] OFS_SLOT_ZERO_STATUS = 20'h000e0;
  localparam logic [19:0] OFS_SLOT_ONE_STATUS  = 20'h000e4;

  localparam int unsigned IRQ_WIDTH = 20;
  localparam logic [IRQ_WIDTH-1:0] IRQ_KEEP_MASK = 20'hFEEFF;

  localparam logic [31:0] SLOT_WR_MASK     = 32'h0000_001f;
  localparam logic [31:0] SLOT_RESET       = 32'h0000_0420;  // ready and no card
  localparam int unsigned SLOT_NO_CARD_BIT = 5;

  localparam logic [3:0] CARD_LINE_ZERO = 4'd9;
  localparam logic [3:0] CARD_LINE_ONE  = 4'd13;

  typedef struct packed {
    logic [1:0]  func;
    logic [19:0] offset;
    logic [31:0] wdata;
    logic [3:0]  line_index;
    logic        line_level;
  } req_item_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        irq_out;
    logic        bad_offset;
  } rsp_item_t;

endpackage

`default_nettype wire

// ===== src/bfir_ifs.sv =====
// Interfaces: request and response channels of the board IRQ register file.
`default_nettype none

interface bfir_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [19:0] offset;
  logic [31:0] wdata;
  logic [3:0]  line_index;
  logic        line_level;

  modport source (output valid, func, offset, wdata, line_index, line_level, input ready);
  modport sink   (input valid, func, offset, wdata, line_index, line_level, output ready);
  modport mon    (input valid, ready, func, offset, wdata, line_index, line_level);
endinterface

interface bfir_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] rdata;
  logic        irq_out;
  logic        bad_offset;

  modport source (output valid, rdata, irq_out, bad_offset, input ready);
  modport sink   (input valid, rdata, irq_out, bad_offset, output ready);
  modport mon    (input valid, ready, rdata, irq_out, bad_offset);
endinterface

`default_nettype wire

// ===== src/bfir_regs.sv =====
// Register file core: register state, address decode and interrupt latch.
`default_nettype none

module bfir_regs (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire bfir_pkg::req_item_t item,
  output bfir_pkg::rsp_item_t      result
);

  logic [31:0] led_data_one, led_data_one_next;
  logic [31:0] led_data_two, led_data_two_next;
  logic [31:0] led_control, led_control_next;
  logic [31:0] switch_word, switch_word_next;
  logic [31:0] misc_write_one, misc_write_one_next;
  logic [31:0] misc_write_two, misc_write_two_next;
  logic [31:0] misc_write_three, misc_write_three_next;
  logic [31:0] misc_read_word, misc_read_word_next;
  logic [bfir_pkg::IRQ_WIDTH-1:0] irq_enable_mask, irq_enable_mask_next;
  logic [bfir_pkg::IRQ_WIDTH-1:0] irq_pending, irq_pending_next;
  logic [31:0] slot_zero_status, slot_zero_status_next;
  logic [31:0] slot_one_status, slot_one_status_next;

  logic                           wr;
  logic                           line_ok;
  logic [bfir_pkg::IRQ_WIDTH-1:0] line_bit;
  logic [31:0]                    rdata;
  logic                           bad;

  assign wr       = (item.func == bfir_pkg::FUNC_WRITE);
  assign line_ok  = ({1'b0, item.line_index} < 5'(bfir_pkg::LINE_COUNT));
  assign line_bit = bfir_pkg::IRQ_WIDTH'(1) << item.line_index;

  always_comb begin
    led_data_one_next     = led_data_one;
    led_data_two_next     = led_data_two;
    led_control_next      = led_control;
    switch_word_next      = switch_word;
    misc_write_one_next   = misc_write_one;
    misc_write_two_next   = misc_write_two;
    misc_write_three_next = misc_write_three;
    misc_read_word_next   = misc_read_word;
    irq_enable_mask_next  = irq_enable_mask;
    irq_pending_next      = irq_pending;
    slot_zero_status_next = slot_zero_status;
    slot_one_status_next  = slot_one_status;
    rdata                 = '0;
    bad                   = 1'b0;

    unique case (item.func)
      bfir_pkg::FUNC_READ, bfir_pkg::FUNC_WRITE: begin
        unique case (item.offset)
          bfir_pkg::OFS_LED_DATA_ONE: begin
            rdata = led_data_one;
            if (wr) led_data_one_next = item.wdata;
          end
          bfir_pkg::OFS_LED_DATA_TWO: begin
            rdata = led_data_two;
            if (wr) led_data_two_next = item.wdata;
          end
          bfir_pkg::OFS_LED_CONTROL: begin
            rdata = led_control;
            if (wr) led_control_next = item.wdata;
          end
          bfir_pkg::OFS_SWITCH_WORD: begin
            rdata = switch_word;
            if (wr) switch_word_next = item.wdata;
          end
          bfir_pkg::OFS_MISC_WRITE_ONE: begin
            rdata = misc_write_one;
            if (wr) misc_write_one_next = item.wdata;
          end
          bfir_pkg::OFS_MISC_WRITE_TWO: begin
            rdata = misc_write_two;
            if (wr) misc_write_two_next = item.wdata;
          end
          bfir_pkg::OFS_MISC_WRITE_THREE: begin
            rdata = misc_write_three;
            if (wr) misc_write_three_next = item.wdata;
          end
          bfir_pkg::OFS_MISC_READ_WORD: begin
            rdata = misc_read_word;
            if (wr) misc_read_word_next = item.wdata;
          end
          bfir_pkg::OFS_IRQ_ENABLE_MASK: begin
            rdata = 32'(irq_enable_mask);
            if (wr) begin
              irq_enable_mask_next = item.wdata[bfir_pkg::IRQ_WIDTH-1:0]
                                     & bfir_pkg::IRQ_KEEP_MASK;
            end
          end
          bfir_pkg::OFS_IRQ_PENDING: begin
            // Plain overwrite, not write-one-to-clear.
            rdata = 32'(irq_pending);
            if (wr) begin
              irq_pending_next = item.wdata[bfir_pkg::IRQ_WIDTH-1:0]
                                 & bfir_pkg::IRQ_KEEP_MASK;
            end
          end
          bfir_pkg::OFS_SLOT_ZERO_STATUS: begin
            rdata = slot_zero_status;
            if (wr) begin
              slot_zero_status_next = (item.wdata & bfir_pkg::SLOT_WR_MASK)
                                      | (slot_zero_status & ~bfir_pkg::SLOT_WR_MASK);
            end
          end
          bfir_pkg::OFS_SLOT_ONE_STATUS: begin
            rdata = slot_one_status;
            if (wr) begin
              slot_one_status_next = (item.wdata & bfir_pkg::SLOT_WR_MASK)
                                     | (slot_one_status & ~bfir_pkg::SLOT_WR_MASK);
            end
          end
          default: bad = 1'b1;
        endcase
        if (bad) rdata = '0;
        if (wr) rdata = '0;
      end
      bfir_pkg::FUNC_LINE: begin
        if (line_ok) begin
          // Card-detect lines drive the active-low card-absent bit.
          if (item.line_index == bfir_pkg::CARD_LINE_ZERO) begin
            slot_zero_status_next[bfir_pkg::SLOT_NO_CARD_BIT] = ~item.line_level;
          end
          if (item.line_index == bfir_pkg::CARD_LINE_ONE) begin
            slot_one_status_next[bfir_pkg::SLOT_NO_CARD_BIT] = ~item.line_level;
          end
          if (item.line_level && ((irq_enable_mask & line_bit) != '0)) begin
            irq_pending_next = (irq_pending | line_bit) & bfir_pkg::IRQ_KEEP_MASK;
          end
        end
      end
      default: ;
    endcase
  end

  assign result.rdata      = rdata;
  assign result.bad_offset = bad;
  assign result.irq_out    = |(irq_pending_next & irq_enable_mask_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      led_data_one     <= '0;
      led_data_two     <= '0;
      led_control      <= '0;
      switch_word      <= '0;
      misc_write_one   <= '0;
      misc_write_two   <= '0;
      misc_write_three <= '0;
      misc_read_word   <= '0;
      irq_enable_mask  <= '0;
      irq_pending      <= '0;
      slot_zero_status <= bfir_pkg::SLOT_RESET;
      slot_one_status  <= bfir_pkg::SLOT_RESET;
    end else if (fire) begin
      led_data_one     <= led_data_one_next;
      led_data_two     <= led_data_two_next;
      led_control      <= led_control_next;
      switch_word      <= switch_word_next;
      misc_write_one   <= misc_write_one_next;
      misc_write_two   <= misc_write_two_next;
      misc_write_three <= misc_write_three_next;
      misc_read_word   <= misc_read_word_next;
      irq_enable_mask  <= irq_enable_mask_next;
      irq_pending      <= irq_pending_next;
      slot_zero_status <= slot_zero_status_next;
      slot_one_status  <= slot_one_status_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/board_fpga_irq_register_file_top.sv =====
// Top level: board control register file with interrupt latch, two-stage beat pipeline.
//
//   channel  dir  handshake      payload
//   -------  ---  -------------  ------------------------------------------------
//   req      in   valid / ready  func, offset, wdata, line_index, line_level
//   rsp      out  valid / ready  rdata, irq_out, bad_offset
//
// One request beat in, one response beat out, in order. Sustained rate is one
// beat per cycle while rsp is ready; a beat passes the input register, then the result register.
// The register file updates as a beat moves from the input register into the
// result register, so irq_out already reflects that beat's own update.
// Synchronous active-high rst clears both valid stages and all register file
// registers (slot status words come up as ready with no card).
// A stalled rsp holds its beat; the input stage still fills behind it.
`default_nettype none

module board_fpga_irq_register_file_top (
  input wire logic clk,
  input wire logic rst,
  bfir_req_if.sink   req,
  bfir_rsp_if.source rsp
);

  // Input stage
  logic                s1_valid;
  bfir_pkg::req_item_t s1_item;

  // Result stage
  logic                rsp_valid;
  bfir_pkg::rsp_item_t rsp_item;

  bfir_pkg::rsp_item_t result;
  logic                advance;
  logic                fire;

  // Advance the result register whenever it is empty or being drained.
  assign advance   = !rsp_valid || rsp.ready;
  // Accept a new beat whenever the input stage is empty or moving on.
  assign req.ready = !s1_valid || advance;
  // Commit the held beat to the register file.
  assign fire      = s1_valid && advance;

  bfir_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (s1_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req.ready) s1_valid <= req.valid;
      if (advance) rsp_valid <= s1_valid;
    end
  end

  // Payload registers: load on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_item.func       <= req.func;
      s1_item.offset     <= req.offset;
      s1_item.wdata      <= req.wdata;
      s1_item.line_index <= req.line_index;
      s1_item.line_level <= req.line_level;
    end
    if (fire) rsp_item <= result;
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.rdata      = rsp_item.rdata;
  assign rsp.irq_out    = rsp_item.irq_out;
  assign rsp.bad_offset = rsp_item.bad_offset;

endmodule

`default_nettype wire

// ===== src/bfir_checker.sv =====
// Checker: port-level assertions for the board IRQ register file, bound to the top level.
`default_nettype none

module bfir_checker (
  input wire logic   clk,
  input wire logic   rst,
  bfir_req_if.sink   req,
  bfir_rsp_if.source rsp
);

  // Response channel comes up empty after reset.
  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !rsp.valid)
    else $error("rsp valid right after reset");

  // A bad offset never returns data.
  a_bad_no_data: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.bad_offset) |-> (rsp.rdata == '0))
    else $error("bad_offset with nonzero rdata");

  // With no result waiting, the input side must take beats.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp.valid |-> req.ready)
    else $error("req stalled while rsp is empty");

  // An accepted beat with a free output reaches rsp through the input and result registers.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) ##1 rsp.ready |=> rsp.valid)
    else $error("accepted beat did not reach rsp");

  // Hold a stalled response beat.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=>
      (rsp.valid && $stable(rsp.rdata) && $stable(rsp.irq_out)
       && $stable(rsp.bad_offset)))
    else $error("stalled rsp beat changed");

endmodule

bind board_fpga_irq_register_file_top bfir_checker u_bfir_checker (
  .clk (clk),
  .rst (rst),
  .req (req),
  .rsp (rsp)
);

`default_nettype wire

// ===== verif/board_irq_reply_checker.sv =====
// Checker: watches both channels, predicts each reply of the register file and compares.
`timescale 1ns / 1ps

module board_irq_reply_checker (
  input  wire logic  clk,
  input  wire logic  rst,
  bfir_req_if.mon    req,
  bfir_rsp_if.mon    rsp,
  output int unsigned mismatches,
  output int unsigned replies_outstanding,
  output int unsigned replies_checked
);

  typedef enum logic [3:0] {
    SEL_LED_ONE, SEL_LED_TWO, SEL_LED_CTRL, SEL_SWITCH,
    SEL_MISC_ONE, SEL_MISC_TWO, SEL_MISC_THREE, SEL_MISC_READ,
    SEL_IRQ_MASK, SEL_IRQ_PEND, SEL_SLOT_ZERO, SEL_SLOT_ONE,
    SEL_NONE
  } reg_sel_t;

  logic [31:0]         shadow [0:11];
  bfir_pkg::rsp_item_t awaited_replies [$];

  initial begin
    mismatches          = 0;
    replies_outstanding = 0;
    replies_checked     = 0;
  end

  function automatic reg_sel_t decode_offset(input logic [19:0] ofs);
    unique case (ofs)
      bfir_pkg::OFS_LED_DATA_ONE:     return SEL_LED_ONE;
      bfir_pkg::OFS_LED_DATA_TWO:     return SEL_LED_TWO;
      bfir_pkg::OFS_LED_CONTROL:      return SEL_LED_CTRL;
      bfir_pkg::OFS_SWITCH_WORD:      return SEL_SWITCH;
      bfir_pkg::OFS_MISC_WRITE_ONE:   return SEL_MISC_ONE;
      bfir_pkg::OFS_MISC_WRITE_TWO:   return SEL_MISC_TWO;
      bfir_pkg::OFS_MISC_WRITE_THREE: return SEL_MISC_THREE;
      bfir_pkg::OFS_MISC_READ_WORD:   return SEL_MISC_READ;
      bfir_pkg::OFS_IRQ_ENABLE_MASK:  return SEL_IRQ_MASK;
      bfir_pkg::OFS_IRQ_PENDING:      return SEL_IRQ_PEND;
      bfir_pkg::OFS_SLOT_ZERO_STATUS: return SEL_SLOT_ZERO;
      bfir_pkg::OFS_SLOT_ONE_STATUS:  return SEL_SLOT_ONE;
      default:                        return SEL_NONE;
    endcase
  endfunction

  task automatic clear_shadow();
    for (int i = 0; i < 12; i++) shadow[i] = '0;
    shadow[SEL_SLOT_ZERO] = bfir_pkg::SLOT_RESET;
    shadow[SEL_SLOT_ONE]  = bfir_pkg::SLOT_RESET;
  endtask

  // Apply one request to the shadow registers and form its reply.
  task automatic board_regs_step(input bfir_pkg::req_item_t b,
                                 output bfir_pkg::rsp_item_t r);
    reg_sel_t    sel;
    logic [31:0] keep;
    keep = {12'd0, bfir_pkg::IRQ_KEEP_MASK};
    r    = '0;
    unique case (b.func)
      bfir_pkg::FUNC_READ, bfir_pkg::FUNC_WRITE: begin
        sel = decode_offset(b.offset);
        if (sel == SEL_NONE) begin
          r.bad_offset = 1'b1;
        end else if (b.func == bfir_pkg::FUNC_READ) begin
          r.rdata = shadow[sel];
        end else begin
          unique case (sel)
            SEL_IRQ_MASK, SEL_IRQ_PEND: shadow[sel] = b.wdata & keep;
            SEL_SLOT_ZERO, SEL_SLOT_ONE:
              shadow[sel] = (b.wdata & bfir_pkg::SLOT_WR_MASK)
                            | (shadow[sel] & ~bfir_pkg::SLOT_WR_MASK);
            default: shadow[sel] = b.wdata;
          endcase
        end
      end
      bfir_pkg::FUNC_LINE: begin
        if (b.line_index < bfir_pkg::LINE_COUNT) begin
          // card-detect bit is active low: a high line means a card is present
          if (b.line_index == bfir_pkg::CARD_LINE_ZERO)
            shadow[SEL_SLOT_ZERO][bfir_pkg::SLOT_NO_CARD_BIT] = ~b.line_level;
          else if (b.line_index == bfir_pkg::CARD_LINE_ONE)
            shadow[SEL_SLOT_ONE][bfir_pkg::SLOT_NO_CARD_BIT] = ~b.line_level;
          if (b.line_level && shadow[SEL_IRQ_MASK][b.line_index])
            shadow[SEL_IRQ_PEND] = (shadow[SEL_IRQ_PEND] | (32'd1 << b.line_index)) & keep;
        end
      end
      default: ;
    endcase
    r.irq_out = |(shadow[SEL_IRQ_PEND] & shadow[SEL_IRQ_MASK]);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    $display("[%0t] reply %0d: %s expected %h, got %h",
             $time, replies_checked, what, want, got);
  endtask

  always @(posedge clk) begin
    bfir_pkg::req_item_t beat;
    bfir_pkg::rsp_item_t want;
    bfir_pkg::rsp_item_t got;
    if (rst) begin
      clear_shadow();
      awaited_replies.delete();
    end else begin
      if (req.valid && req.ready) begin
        beat.func       = req.func;
        beat.offset     = req.offset;
        beat.wdata      = req.wdata;
        beat.line_index = req.line_index;
        beat.line_level = req.line_level;
        board_regs_step(beat, want);
        awaited_replies.push_back(want);
      end
      if (rsp.valid && rsp.ready) begin
        got.rdata      = rsp.rdata;
        got.irq_out    = rsp.irq_out;
        got.bad_offset = rsp.bad_offset;
        if (awaited_replies.size() == 0) begin
          report_mismatch("reply with none awaited, rdata", '0, got.rdata);
        end else begin
          want = awaited_replies.pop_front();
          if (got.rdata !== want.rdata)
            report_mismatch("rdata", want.rdata, got.rdata);
          if (got.irq_out !== want.irq_out)
            report_mismatch("irq_out", 32'(want.irq_out), 32'(got.irq_out));
          if (got.bad_offset !== want.bad_offset)
            report_mismatch("bad_offset", 32'(want.bad_offset), 32'(got.bad_offset));
        end
        replies_checked++;
      end
    end
    replies_outstanding <= awaited_replies.size();
  end

endmodule

// ===== verif/testbench.sv =====
// Testbench top: drives requests and response stalls into the register file, gives the verdict.
`timescale 1ns / 1ps

module testbench;

  // Function code 3 is unassigned; the block must answer it without side effects.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam int unsigned LONG_HOLD   = 50;      // cycles of the long response hold-off
  localparam int unsigned CYCLE_LIMIT = 200000;  // far beyond the slowest correct run
  localparam int unsigned DRAIN_WAIT  = 8;       // slack after the last reply

  logic clk;
  logic rst;

  bfir_req_if req_ch ();
  bfir_rsp_if rsp_ch ();

  int unsigned mismatches;
  int unsigned replies_outstanding;
  int unsigned replies_checked;

  int unsigned cycle_count = 0;
  int unsigned sent_beats  = 0;
  int unsigned directed_beats = 0;
  int unsigned long_holds  = 0;

  // Handshake flags between the sender and the receiver process.
  bit hold_rsp_req = 1'b0;
  bit quiet_tail   = 1'b0;

  board_fpga_irq_register_file_top i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  board_irq_reply_checker i_checker (
    .clk                 (clk),
    .rst                 (rst),
    .req                 (req_ch),
    .rsp                 (rsp_ch),
    .mismatches          (mismatches),
    .replies_outstanding (replies_outstanding),
    .replies_checked     (replies_checked)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Stop a hung run: a missing reply or a stuck handshake ends here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d replies still awaited",
             cycle_count, replies_outstanding);
    $display("Mismatches found");
    $finish;
  end

  // Offer one beat from the falling edge and hold it until the block takes it.
  // Return at the falling edge after acceptance, with nothing yet driven there.
  task automatic send_beat(input logic [1:0] f, input logic [19:0] ofs,
                           input logic [31:0] wd, input logic [3:0] li, input logic lv);
    req_ch.valid      <= 1'b1;
    req_ch.func       <= f;
    req_ch.offset     <= ofs;
    req_ch.wdata      <= wd;
    req_ch.line_index <= li;
    req_ch.line_level <= lv;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    sent_beats++;
  endtask

  // Drop valid for a short random burst.
  task automatic sender_gap();
    req_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  function automatic logic [19:0] pick_register_offset();
    unique case ($urandom_range(0, 11))
      0:       return bfir_pkg::OFS_LED_DATA_ONE;
      1:       return bfir_pkg::OFS_LED_DATA_TWO;
      2:       return bfir_pkg::OFS_LED_CONTROL;
      3:       return bfir_pkg::OFS_SWITCH_WORD;
      4:       return bfir_pkg::OFS_MISC_WRITE_ONE;
      5:       return bfir_pkg::OFS_MISC_WRITE_TWO;
      6:       return bfir_pkg::OFS_MISC_WRITE_THREE;
      7:       return bfir_pkg::OFS_MISC_READ_WORD;
      8:       return bfir_pkg::OFS_IRQ_ENABLE_MASK;
      9:       return bfir_pkg::OFS_IRQ_PENDING;
      10:      return bfir_pkg::OFS_SLOT_ZERO_STATUS;
      default: return bfir_pkg::OFS_SLOT_ONE_STATUS;
    endcase
  endfunction

  // Mostly mapped accesses and line changes; some near-miss and wild offsets.
  task automatic send_random_beat();
    int unsigned   pick;
    logic [1:0]    f;
    logic [19:0]   ofs;
    logic [31:0]   wd;
    pick = $urandom_range(0, 99);
    if (pick < 30)      f = bfir_pkg::FUNC_READ;
    else if (pick < 60) f = bfir_pkg::FUNC_WRITE;
    else if (pick < 95) f = bfir_pkg::FUNC_LINE;
    else                f = FUNC_UNUSED;
    pick = $urandom_range(0, 9);
    if (pick < 8)       ofs = pick_register_offset();
    else if (pick == 8) ofs = pick_register_offset() ^ (20'd1 << $urandom_range(0, 19));
    else                ofs = 20'($urandom);
    wd = $urandom;
    // clear pending often so the interrupt output keeps toggling
    if (f == bfir_pkg::FUNC_WRITE && ofs == bfir_pkg::OFS_IRQ_PENDING
        && $urandom_range(0, 1) == 1)
      wd = '0;
    send_beat(f, ofs, wd, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endtask

  // Receiver: random stall bursts, one long hold-off on request, none in the tail.
  initial begin
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_rsp_req) begin
        hold_rsp_req = 1'b0;
        long_holds++;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        rsp_ch.ready <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Sender: reset, directed beats, then random phases.
  initial begin
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.func       = bfir_pkg::FUNC_READ;
    req_ch.offset     = '0;
    req_ch.wdata      = '0;
    req_ch.line_index = '0;
    req_ch.line_level = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset values: slot status ready with no card, pending clear.
    send_beat(bfir_pkg::FUNC_READ,  bfir_pkg::OFS_SLOT_ZERO_STATUS, 32'h0, 4'd0, 1'b0);
    send_beat(bfir_pkg::FUNC_READ,  bfir_pkg::OFS_IRQ_PENDING,      32'h0, 4'd0, 1'b0);
    // Full-width store and readback.
    send_beat(bfir_pkg::FUNC_WRITE, bfir_pkg::OFS_LED_DATA_ONE, 32'hFFFF_FFFF, 4'd15, 1'b1);
    send_beat(bfir_pkg::FUNC_READ,  bfir_pkg::OFS_LED_DATA_ONE, 32'h0, 4'd0, 1'b0);
    // Mask keeps only its allowed bits.
    send_beat(bfir_pkg::FUNC_WRITE, bfir_pkg::OFS_IRQ_ENABLE_MASK, 32'hFFFF_FFFF, 4'd0, 1'b0);
    send_beat(bfir_pkg::FUNC_READ,  bfir_pkg::OFS_IRQ_ENABLE_MASK, 32'h0, 4'd0, 1'b0);
    // Latch a line; lines 8 and 12 fall outside the kept bits.
    send_beat(bfir_pkg::FUNC_LINE,  20'h0, 32'h0, 4'd0,  1'b1);
    send_beat(bfir_pkg::FUNC_LINE,  20'h0, 32'h0, 4'd8,  1'b1);
    send_beat(bfir_pkg::FUNC_LINE,  20'h0, 32'h0, 4'd12, 1'b1);
    send_beat(bfir_pkg::FUNC_READ,  bfir_pkg::OFS_IRQ_PENDING, 32'h0, 4'd0, 1'b0);
    // Card-detect lines flip the no-card bit of their slot.
    send_beat(bfir_pkg::FUNC_LINE,  20'h0, 32'h0, bfir_pkg::CARD_LINE_ZERO, 1'b1);
    send_beat(bfir_pkg::FUNC_READ,  bfir_pkg::OFS_SLOT_ZERO_STATUS, 32'h0, 4'd0, 1'b0);
    send_beat(bfir_pkg::FUNC_LINE,  20'h0, 32'h0, bfir_pkg::CARD_LINE_ONE,  1'b0);
    send_beat(bfir_pkg::FUNC_LINE,  20'h0, 32'h0, bfir_pkg::CARD_LINE_ONE,  1'b1);
    // Slot writes touch only the low five bits.
    send_beat(bfir_pkg::FUNC_WRITE, bfir_pkg::OFS_SLOT_ONE_STATUS, 32'hFFFF_FFFF, 4'd0, 1'b0);
    send_beat(bfir_pkg::FUNC_READ,  bfir_pkg::OFS_SLOT_ONE_STATUS, 32'h0, 4'd0, 1'b0);
    // Pending is overwritten directly, not cleared by ones.
    send_beat(bfir_pkg::FUNC_WRITE, bfir_pkg::OFS_IRQ_PENDING, 32'h0, 4'd0, 1'b0);
    // Unmapped offsets at both ends of the window, and the unused function.
    send_beat(bfir_pkg::FUNC_READ,  20'hF_FFFF, 32'hFFFF_FFFF, 4'd0, 1'b0);
    send_beat(bfir_pkg::FUNC_WRITE, 20'h0_0000, 32'hA5A5_5A5A, 4'd0, 1'b0);
    send_beat(FUNC_UNUSED, bfir_pkg::OFS_LED_DATA_ONE, 32'h0, 4'd0, 1'b1);
    send_beat(bfir_pkg::FUNC_LINE,  20'h0, 32'h0, 4'd15, 1'b1);
    send_beat(bfir_pkg::FUNC_LINE,  20'h0, 32'h0, bfir_pkg::CARD_LINE_ZERO, 1'b0);
    send_beat(bfir_pkg::FUNC_WRITE, bfir_pkg::OFS_IRQ_PENDING, 32'hFFFF_FFFF, 4'd0, 1'b0);
    send_beat(bfir_pkg::FUNC_READ,  bfir_pkg::OFS_IRQ_PENDING, 32'h0, 4'd0, 1'b0);
    send_beat(bfir_pkg::FUNC_WRITE, bfir_pkg::OFS_IRQ_ENABLE_MASK, 32'h0, 4'd0, 1'b0);
    directed_beats = sent_beats;

    // Random traffic with gaps on both sides.
    for (int i = 0; i < 250; i++) begin
      send_random_beat();
      if ($urandom_range(0, 5) == 0) sender_gap();
    end

    // Pause the sender until every reply is back.
    req_ch.valid <= 1'b0;
    wait (replies_outstanding == 0);
    @(negedge clk);

    // Hold off the receiver for a long stretch and keep offering beats,
    // so the pipeline fills and back-pressures the request side.
    hold_rsp_req = 1'b1;
    for (int i = 0; i < 250; i++) begin
      send_random_beat();
      if (i >= 30 && $urandom_range(0, 5) == 0) sender_gap();
    end

    // Tail: no idling anywhere, back-to-back beats.
    quiet_tail = 1'b1;
    for (int i = 0; i < 200; i++) send_random_beat();
    req_ch.valid <= 1'b0;

    wait (replies_outstanding == 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d request beats (%0d directed, rest random accesses and line changes)",
             sent_beats, directed_beats);
    $display("%0d replies checked, with sender gaps, reply stalls, %0d long hold-off(s), a drain",
             replies_checked, long_holds);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
